/* rtl/core/cbdp_pkg.sv */
package cbdp_pkg;

  localparam int ByteW  = 8;
  localparam int IdW    = 16;
  localparam int EventW = 3;
  localparam int FieldW = 2;

  typedef enum logic [EventW-1:0] {
    EV_HEADER  = 3'd0,
    EV_REPLY   = 3'd1,
    EV_CHAR    = 3'd2,
    EV_END     = 3'd3,
    EV_BAD     = 3'd4,
    EV_UNKNOWN = 3'd5
  } event_t;

  localparam logic [ByteW-1:0] T_CONFIRM = 8'h00;
  localparam logic [ByteW-1:0] T_REPLY   = 8'h01;
  localparam logic [ByteW-1:0] T_AUTH    = 8'h02;
  localparam logic [ByteW-1:0] T_JOIN    = 8'h03;
  localparam logic [ByteW-1:0] T_MSG     = 8'h04;
  localparam logic [ByteW-1:0] T_ERR     = 8'hFE;
  localparam logic [ByteW-1:0] T_BYE     = 8'hFF;

  localparam logic [FieldW-1:0] AuthLastField  = 2'd2;
  localparam logic [FieldW-1:0] OtherLastField = 2'd1;

  typedef struct packed {
    event_t              ev;
    logic [ByteW-1:0]    msg_type;
    logic [IdW-1:0]      msg_id;
    logic                reply_ok;
    logic [IdW-1:0]      ref_id;
    logic [FieldW-1:0]   field_index;
    logic [ByteW-1:0]    field_char;
    logic                packet_end;
  } res_t;

endpackage

/* rtl/core/chat_binary_datagram_parser_top.sv */
// Chat datagram parser: takes one datagram byte per transfer, with last_byte flagging the
// final byte, and returns at most one event per byte (header-only packet, reply header, field
// character, field end, malformed, unknown type) together with the held type, id, ok flag and
// reference id. The byte is decoded in the cycle it is transferred; its event is registered into
// the output register, or into the skid register while the output is stalled. The one-entry skid
// register behind the output register keeps the input running while the output is stalled: a new
// byte is taken every cycle, and the input stalls only once that skid entry is occupied.
module chat_binary_datagram_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cbdp_pkg::ByteW-1:0]    data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cbdp_pkg::EventW-1:0]   event_res,
  output logic [cbdp_pkg::ByteW-1:0]    msg_type,
  output logic [cbdp_pkg::IdW-1:0]      msg_id,
  output logic                          reply_ok,
  output logic [cbdp_pkg::IdW-1:0]      ref_id,
  output logic [cbdp_pkg::FieldW-1:0]   field_index,
  output logic [cbdp_pkg::ByteW-1:0]    field_char,
  output logic                          packet_end
);
  import cbdp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ID_HI, PH_ID_LO, PH_OK, PH_REF_HI, PH_REF_LO, PH_TEXT, PH_FIELDS, PH_SKIP
  } phase_t;

  phase_t              phase, phase_next;
  logic [ByteW-1:0]    held_type, held_type_next;
  logic [IdW-1:0]      held_id, held_id_next;
  logic [IdW-1:0]      held_ref, held_ref_next;
  logic                held_ok, held_ok_next;
  logic [FieldW-1:0]   cur_field, cur_field_next;

  res_t  out_q, skid_q, res;
  logic  skid_valid;
  logic  emit;
  logic  accept;
  logic  known_type;
  logic  final_field;
  phase_t after_pkt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;

  always_comb begin
    phase_next     = phase;
    held_type_next = held_type;
    held_id_next   = held_id;
    held_ref_next  = held_ref;
    held_ok_next   = held_ok;
    cur_field_next = cur_field;
    emit           = 1'b0;
    res            = '0;
    after_pkt      = last_byte ? PH_IDLE : PH_SKIP;
    known_type     = (held_type == T_REPLY) || (held_type == T_AUTH) ||
                     (held_type == T_JOIN) || (held_type == T_MSG) || (held_type == T_ERR);
    final_field    = (held_type == T_AUTH) ? (cur_field >= AuthLastField)
                                           : (cur_field >= OtherLastField);
    case (phase)
      PH_IDLE: begin
        held_type_next = data_byte;
        held_id_next   = '0;
        held_ref_next  = '0;
        held_ok_next   = 1'b0;
        cur_field_next = '0;
        if (last_byte) begin
          emit = 1'b1; res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
        end else begin
          phase_next = PH_ID_HI;
        end
      end
      PH_ID_HI: begin
        held_id_next = {data_byte, {ByteW{1'b0}}};
        if (last_byte) begin
          emit = 1'b1; res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
        end else begin
          phase_next = PH_ID_LO;
        end
      end
      PH_ID_LO: begin
        held_id_next = {held_id[IdW-1:ByteW], data_byte};
        if (held_type == T_CONFIRM || held_type == T_BYE) begin
          emit = 1'b1; res.ev = EV_HEADER; res.packet_end = 1'b1; phase_next = after_pkt;
        end else if (known_type) begin
          if (last_byte) begin
            emit = 1'b1; res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
          end else begin
            cur_field_next = '0;
            phase_next = (held_type == T_REPLY) ? PH_OK : PH_FIELDS;
          end
        end else begin
          emit = 1'b1; res.ev = EV_UNKNOWN; res.packet_end = 1'b1; phase_next = after_pkt;
        end
      end
      PH_OK: begin
        if (data_byte > 8'd1) begin
          emit = 1'b1; res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = after_pkt;
        end else begin
          held_ok_next = data_byte[0];
          if (last_byte) begin
            emit = 1'b1; res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
          end else begin
            phase_next = PH_REF_HI;
          end
        end
      end
      PH_REF_HI: begin
        held_ref_next = {data_byte, {ByteW{1'b0}}};
        if (last_byte) begin
          emit = 1'b1; res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
        end else begin
          phase_next = PH_REF_LO;
        end
      end
      PH_REF_LO: begin
        held_ref_next  = {held_ref[IdW-1:ByteW], data_byte};
        emit           = 1'b1;
        res.ev         = EV_REPLY;
        res.packet_end = last_byte;
        phase_next     = last_byte ? PH_IDLE : PH_TEXT;
      end
      PH_TEXT: begin
        emit = 1'b1;
        if (data_byte == '0) begin
          res.ev = EV_END; res.packet_end = 1'b1; phase_next = after_pkt;
        end else begin
          res.ev = EV_CHAR; res.field_char = data_byte; res.packet_end = last_byte;
          if (last_byte) begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_FIELDS: begin
        emit = 1'b1;
        if (data_byte == '0) begin
          if (final_field) begin
            res.ev = EV_END; res.field_index = cur_field; res.packet_end = 1'b1;
            phase_next = after_pkt;
          end else if (last_byte) begin
            res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
          end else begin
            res.ev = EV_END; res.field_index = cur_field;
            cur_field_next = cur_field + 2'd1;
          end
        end else if (last_byte) begin
          res.ev = EV_BAD; res.packet_end = 1'b1; phase_next = PH_IDLE;
        end else begin
          res.ev = EV_CHAR; res.field_index = cur_field; res.field_char = data_byte;
        end
      end
      default: begin
        phase_next = last_byte ? PH_IDLE : PH_SKIP;
      end
    endcase
    res.msg_type = held_type_next;
    res.msg_id   = held_id_next;
    res.reply_ok = held_ok_next;
    res.ref_id   = held_ref_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_type  <= '0;
      held_id    <= '0;
      held_ref   <= '0;
      held_ok    <= 1'b0;
      cur_field  <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        held_type <= held_type_next;
        held_id   <= held_id_next;
        held_ref  <= held_ref_next;
        held_ok   <= held_ok_next;
        cur_field <= cur_field_next;
      end
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_q     <= res;
          out_valid <= accept && emit;
        end
      end else if (accept && emit) begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign event_res   = out_q.ev;
  assign msg_type    = out_q.msg_type;
  assign msg_id      = out_q.msg_id;
  assign reply_ok    = out_q.reply_ok;
  assign ref_id      = out_q.ref_id;
  assign field_index = out_q.field_index;
  assign field_char  = out_q.field_char;
  assign packet_end  = out_q.packet_end;

endmodule
